[hw/rtl/bgd_pkg.sv]
// Shared types and constants for the button gesture detector.
// No dependencies.
package bgd_pkg;

  localparam int NUM_BUTTONS_DEF = 6;
  localparam int IDX_W = 3;
  localparam int TIME_W = 32;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int IN_TDATA_W = 40;
  localparam int OUT_TDATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLICK_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_CLICK = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd3;

  localparam logic [CFG_W-1:0] CLICK_MAX_RST = 16'd300;
  localparam logic [CFG_W-1:0] DOUBLE_CLICK_RST = 16'd300;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd2000;

  typedef struct packed {
    logic              enable;
    logic [CFG_W-1:0]  click_max_ms;
    logic [CFG_W-1:0]  double_click_ms;
    logic [CFG_W-1:0]  long_press_ms;
  } bgd_cfg_t;

  typedef struct packed {
    logic              last_level;
    logic [TIME_W-1:0] press_stamp;
    logic [TIME_W-1:0] click_stamp;
    logic              click_pending;
    logic              hold_done;
  } bgd_state_t;

  localparam int STATE_W = $bits(bgd_state_t);

  typedef struct packed {
    logic long_press_event;
    logic double_click_event;
    logic click_event;
    logic release_event;
    logic press_event;
  } bgd_events_t;

endpackage

[hw/rtl/bgd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bgd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/bgd_update.sv]
// Per-button gesture update: next state and events from the stored state.
// Depends on bgd_pkg.
module bgd_update import bgd_pkg::*; (
  input  bgd_cfg_t            cfg,
  input  logic                pressed,
  input  logic [TIME_W-1:0]   now_ms,
  input  bgd_state_t          cur,
  output bgd_state_t          nxt,
  output bgd_events_t         ev
);

  logic              rise;
  logic              fall;
  logic              dbl;
  logic              click;
  logic              long_hit;
  logic              hold_mid;
  logic [TIME_W-1:0] press_mid;
  logic [TIME_W-1:0] since_click;
  logic [TIME_W-1:0] since_press;
  logic [TIME_W-1:0] held_for;

  always_comb begin
    rise        = pressed & ~cur.last_level;
    fall        = ~pressed & cur.last_level;
    since_click = now_ms - cur.click_stamp;
    since_press = now_ms - cur.press_stamp;
    dbl         = rise & cur.click_pending &
                  (since_click < TIME_W'(cfg.double_click_ms));
    click       = fall & (since_press < TIME_W'(cfg.click_max_ms));
    press_mid   = rise ? now_ms : cur.press_stamp;
    hold_mid    = rise ? 1'b0 : cur.hold_done;
    held_for    = now_ms - press_mid;
    long_hit    = pressed & ~hold_mid & (held_for >= TIME_W'(cfg.long_press_ms));

    nxt.last_level    = pressed;
    nxt.press_stamp   = press_mid;
    nxt.click_stamp   = click ? now_ms : cur.click_stamp;
    nxt.hold_done     = hold_mid | long_hit;
    if (dbl) begin
      nxt.click_pending = 1'b0;
    end else if (fall) begin
      nxt.click_pending = click;
    end else begin
      nxt.click_pending = cur.click_pending;
    end

    ev.press_event        = rise;
    ev.release_event      = fall;
    ev.click_event        = click;
    ev.double_click_event = dbl;
    ev.long_press_event   = long_hit;
  end

endmodule

[hw/rtl/button_gesture_detector.sv]
// Button gesture detector top level: config registers, state RAM pipeline,
// output register. Depends on bgd_pkg, bgd_ram and bgd_update.
//
// Usage: each input transaction on s_* carries one button sample
// (index, level, millisecond timestamp); each produces exactly one output
// transaction on m_* with five event flags. Per-button state lives in a
// RAM of NUM_BUTTONS entries read in the accept cycle and written back
// when the result moves to the output register; a write-forwarding
// register covers back-to-back samples of the same button.
// Path: an accepted sample is registered into the RAM stage (s1), then into
// the output register, which raises m_tvalid and holds it until taken.
// Throughput: one sample per cycle while m_tready does not stall the output, set by the single RAM read/write pass.
// Reset: config returns to enable=1, click 300 ms, double click 300 ms,
// long press 2000 ms; per-entry valid bits make every button read as
// released with zero stamps, so no clearing pass is needed.
// Stall: the output register holds while m_tready is low; one more
// sample waits in the RAM stage, after which s_tready drops.
// Disabled block or index out of range: all flags zero, state untouched.
// Configuration is written through cfg_we/cfg_index/cfg_wdata while idle.
module button_gesture_detector import bgd_pkg::*; #(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // [2:0] button_index, [3] pressed, [35:4] now_ms, [39:36] zero
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [0] press_event, [1] release_event, [2] click_event,
  // [3] double_click_event, [4] long_press_event, [7:5] zero
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam int AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  bgd_cfg_t          cfg;
  logic              s_accept;
  logic              s1_valid;
  logic [IDX_W-1:0]  s1_idx;
  logic              s1_pressed;
  logic [TIME_W-1:0] s1_now;
  logic              s1_fire;
  logic              s1_in_range;
  logic              s1_active;
  logic [AW-1:0]     s1_addr;
  logic [STATE_W-1:0] ram_rdata;
  logic [NUM_BUTTONS-1:0] entry_valid;
  logic              wr_valid;
  logic [AW-1:0]     wr_addr;
  bgd_state_t        wr_data;
  bgd_state_t        st_cur;
  bgd_state_t        st_nxt;
  bgd_events_t       ev;
  bgd_events_t       out_ev;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable          <= 1'b1;
      cfg.click_max_ms    <= CLICK_MAX_RST;
      cfg.double_click_ms <= DOUBLE_CLICK_RST;
      cfg.long_press_ms   <= LONG_PRESS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLE:       cfg.enable          <= cfg_wdata[0];
        CFG_CLICK_MAX:    cfg.click_max_ms    <= cfg_wdata;
        CFG_DOUBLE_CLICK: cfg.double_click_ms <= cfg_wdata;
        CFG_LONG_PRESS:   cfg.long_press_ms   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign s1_fire  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_fire;
  assign s_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_idx     <= s_tdata[2:0];
      s1_pressed <= s_tdata[3];
      s1_now     <= s_tdata[35:4];
    end
  end

  bgd_ram #(
    .WIDTH(STATE_W),
    .DEPTH(NUM_BUTTONS)
  ) u_state_ram (
    .clk   (clk),
    .we    (s1_fire && s1_active),
    .waddr (s1_addr),
    .wdata (st_nxt),
    .re    (s_accept),
    .raddr (AW'(s_tdata[2:0])),
    .rdata (ram_rdata)
  );

  assign s1_addr     = AW'(s1_idx);
  assign s1_in_range = 32'(s1_idx) < NUM_BUTTONS;
  assign s1_active   = cfg.enable && s1_in_range;

  always_comb begin
    if (wr_valid && wr_addr == s1_addr) begin
      st_cur = wr_data;
    end else if (s1_in_range && entry_valid[s1_addr]) begin
      st_cur = bgd_state_t'(ram_rdata);
    end else begin
      st_cur = '0;
    end
  end

  bgd_update u_update (
    .cfg     (cfg),
    .pressed (s1_pressed),
    .now_ms  (s1_now),
    .cur     (st_cur),
    .nxt     (st_nxt),
    .ev      (ev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      wr_valid    <= 1'b0;
    end else if (s1_fire && s1_active) begin
      entry_valid[s1_addr] <= 1'b1;
      wr_valid             <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_active) begin
      wr_addr <= s1_addr;
      wr_data <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_ev <= s1_active ? ev : '0;
    end
  end

  assign m_tdata = {3'b000, out_ev};

  a_no_press_and_release: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(out_ev.press_event && out_ev.release_event))
    else $error("press and release flagged on one sample");

  a_click_needs_release: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_ev.click_event |-> out_ev.release_event)
    else $error("click without release");

  a_double_needs_press: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_ev.double_click_event |-> out_ev.press_event)
    else $error("double click without press");

  a_ready_when_out_free: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output register");

  a_accept_reaches_s1: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> s1_valid)
    else $error("accepted sample lost before RAM stage");

endmodule

[sim/button_gesture_checker.sv]
// Checker for button_gesture_detector: tracks config writes, predicts the event flags
// of every accepted sample and compares them with the output stream.
// Depends on bgd_pkg.
`timescale 1ns / 1ps
module button_gesture_checker import bgd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  // [2:0] button_index, [3] pressed, [35:4] now_ms, [39:36] zero
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  // [0] press_event, [1] release_event, [2] click_event,
  // [3] double_click_event, [4] long_press_event, [7:5] zero
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  output int                     fail_count,
  output int                     pending_results
);

  bgd_cfg_t          cfg;
  logic              level_q    [NUM_BUTTONS_DEF];
  logic [TIME_W-1:0] press_at   [NUM_BUTTONS_DEF];
  logic [TIME_W-1:0] click_at   [NUM_BUTTONS_DEF];
  logic              click_armed[NUM_BUTTONS_DEF];
  logic              long_fired [NUM_BUTTONS_DEF];
  bgd_events_t       events_due[$];

  function automatic bgd_events_t detect_gestures(logic [IDX_W-1:0] idx, logic lvl,
                                                  logic [TIME_W-1:0] now);
    bgd_events_t       ev;
    logic              was_down;
    logic [TIME_W-1:0] since;
    ev = '0;
    if (cfg.enable && idx < NUM_BUTTONS_DEF) begin
      was_down = level_q[idx];
      level_q[idx] = lvl;
      if (lvl && !was_down) begin
        ev.press_event = 1'b1;
        press_at[idx] = now;
        long_fired[idx] = 1'b0;
        since = now - click_at[idx];
        if (click_armed[idx] && since < {16'd0, cfg.double_click_ms}) begin
          click_armed[idx] = 1'b0;
          ev.double_click_event = 1'b1;
        end
      end
      if (!lvl && was_down) begin
        ev.release_event = 1'b1;
        since = now - press_at[idx];
        if (since < {16'd0, cfg.click_max_ms}) begin
          ev.click_event = 1'b1;
          click_armed[idx] = 1'b1;
          click_at[idx] = now;
        end else begin
          click_armed[idx] = 1'b0;
        end
      end
      since = now - press_at[idx];
      if (lvl && !long_fired[idx] && since >= {16'd0, cfg.long_press_ms}) begin
        ev.long_press_event = 1'b1;
        long_fired[idx] = 1'b1;
      end
    end
    return ev;
  endfunction

  task automatic note_failure(string what, bgd_events_t exp, bgd_events_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t %s: expected %05b got %05b (long,double,click,release,press)",
               $realtime, what, exp, got);
  endtask

  always @(posedge clk) begin
    bgd_events_t got;
    bgd_events_t exp;
    if (rst) begin
      cfg = {1'b1, CLICK_MAX_RST, DOUBLE_CLICK_RST, LONG_PRESS_RST};
      for (int b = 0; b < NUM_BUTTONS_DEF; b++) begin
        level_q[b] = 1'b0;
        press_at[b] = '0;
        click_at[b] = '0;
        click_armed[b] = 1'b0;
        long_fired[b] = 1'b0;
      end
      events_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = bgd_events_t'(m_tdata[$bits(bgd_events_t)-1:0]);
        if (events_due.size() == 0) begin
          note_failure("unexpected result", '0, got);
        end else begin
          exp = events_due.pop_front();
          if (got.press_event !== exp.press_event ||
              got.release_event !== exp.release_event ||
              got.click_event !== exp.click_event ||
              got.double_click_event !== exp.double_click_event ||
              got.long_press_event !== exp.long_press_event)
            note_failure("event mismatch", exp, got);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_ENABLE:       cfg.enable = cfg_wdata[0];
          CFG_CLICK_MAX:    cfg.click_max_ms = cfg_wdata;
          CFG_DOUBLE_CLICK: cfg.double_click_ms = cfg_wdata;
          CFG_LONG_PRESS:   cfg.long_press_ms = cfg_wdata;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        events_due.insert(events_due.size(),
                          detect_gestures(s_tdata[IDX_W-1:0], s_tdata[IDX_W],
                                          s_tdata[IDX_W+1 +: TIME_W]));
    end
    pending_results = events_due.size();
  end

endmodule

[sim/button_gesture_detector_tb.sv]
// Testbench top for button_gesture_detector: clock, reset, sample and config stimulus,
// output backpressure and the verdict. Depends on bgd_pkg and button_gesture_checker.
`timescale 1ns / 1ps
module button_gesture_detector_tb;
  import bgd_pkg::*;

  localparam int CYCLE_LIMIT     = 300000;
  localparam int HOLD_OFF_CYCLES = 200;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]       cfg_wdata;
  logic                   s_tvalid;
  logic                   s_tready;
  // [2:0] button_index, [3] pressed, [35:4] now_ms, [39:36] zero
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  // [0] press_event, [1] release_event, [2] click_event,
  // [3] double_click_event, [4] long_press_event, [7:5] zero
  logic [OUT_TDATA_W-1:0] m_tdata;

  int                fail_count;
  int                pending_results;
  int                cycle_count;
  int                samples_sent;
  int                hold_left;
  bit                idle_on;
  bit                stall_req;
  logic [TIME_W-1:0] t_now;
  int                click_lim;
  int                dbl_lim;
  int                long_lim;

  button_gesture_detector dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  button_gesture_checker chk (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .pending_results(pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // output backpressure; a hold-off request stalls the receiver for a long stretch
  initial begin
    m_tready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (stall_req) begin
        stall_req = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        m_tready = 1'b0;
        hold_left--;
      end else begin
        m_tready = idle_on ? ($urandom_range(99) >= 38) : 1'b1;
      end
    end
  end

  task automatic send_sample(input logic [IDX_W-1:0] idx, input logic lvl,
                             input logic [TIME_W-1:0] now);
    if (idle_on) begin
      while ($urandom_range(99) < 38) begin
        s_tvalid = 1'b0;
        @(negedge clk);
      end
    end
    s_tvalid = 1'b1;
    s_tdata = {{(IN_TDATA_W-IDX_W-1-TIME_W){1'b0}}, now, lvl, idx};
    do @(posedge clk); while (!s_tready);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid = 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = CFG_W'(value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic configure(input bit en, input int click, input int dbl, input int lng);
    drain();
    write_reg(CFG_ENABLE, int'(en));
    write_reg(CFG_CLICK_MAX, click);
    write_reg(CFG_DOUBLE_CLICK, dbl);
    write_reg(CFG_LONG_PRESS, lng);
    click_lim = click;
    dbl_lim = dbl;
    long_lim = lng;
  endtask

  function automatic logic [TIME_W-1:0] near(input int limit);
    case ($urandom_range(5))
      0:       return TIME_W'(limit - 1);
      1:       return TIME_W'(limit);
      2:       return TIME_W'(limit + 1);
      3:       return '0;
      default: return TIME_W'($urandom_range(2 * limit + 1));
    endcase
  endfunction

  task automatic advance();
    case ($urandom_range(19))
      0:       t_now = $urandom;
      1:       t_now = 32'hFFFF_FFFF - $urandom_range(3000);
      default: t_now += $urandom_range(70000);
    endcase
  endtask

  task automatic play_gesture();
    logic [IDX_W-1:0]  b;
    logic [TIME_W-1:0] p;
    b = IDX_W'($urandom_range(NUM_BUTTONS_DEF - 1));
    advance();
    case ($urandom_range(9))
      0: send_sample(IDX_W'($urandom_range(7)), 1'($urandom_range(1)), $urandom);
      1: send_sample(b, 1'($urandom_range(1)), t_now);
      default: begin
        p = t_now;
        send_sample(b, 1'b1, p);
        repeat ($urandom_range(2)) send_sample(b, 1'b1, p + near(long_lim));
        t_now = p + ($urandom_range(1) ? near(click_lim) : near(long_lim));
        send_sample(b, 1'b0, t_now);
        if ($urandom_range(1)) begin
          t_now += near(dbl_lim);
          send_sample(b, 1'b1, t_now);
          t_now += near(click_lim);
          send_sample(b, 1'b0, t_now);
        end
      end
    endcase
  endtask

  task automatic run_phase(input int n);
    int stop_at;
    stop_at = samples_sent + n;
    while (samples_sent < stop_at) play_gesture();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_ENABLE;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    idle_on = 1'b0;
    stall_req = 1'b0;
    samples_sent = 0;
    t_now = '0;
    click_lim = int'(CLICK_MAX_RST);
    dbl_lim = int'(DOUBLE_CLICK_RST);
    long_lim = int'(LONG_PRESS_RST);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // click, double click, late second press, long press once, long release
    send_sample(3'd0, 1'b1, 32'd0);
    send_sample(3'd0, 1'b0, 32'd299);
    send_sample(3'd0, 1'b1, 32'd598);
    send_sample(3'd0, 1'b0, 32'd600);
    send_sample(3'd0, 1'b1, 32'd900);
    send_sample(3'd0, 1'b1, 32'd2899);
    send_sample(3'd0, 1'b1, 32'd2900);
    send_sample(3'd0, 1'b1, 32'd40000);
    send_sample(3'd0, 1'b0, 32'd40001);
    send_sample(3'd0, 1'b1, 32'd40100);
    // click and double click across the timestamp wrap
    send_sample(3'd5, 1'b1, 32'hFFFF_FFF0);
    send_sample(3'd5, 1'b0, 32'h0000_0010);
    send_sample(3'd5, 1'b1, 32'h0000_0100);
    send_sample(3'd5, 1'b1, 32'h0000_0101);
    send_sample(3'd5, 1'b0, 32'h0000_0200);
    // indexes beyond the last button
    send_sample(3'd6, 1'b1, 32'hFFFF_FFFF);
    send_sample(3'd7, 1'b0, 32'h0000_0000);
    // release without press, long press threshold edge
    send_sample(3'd1, 1'b0, 32'h5555_5555);
    send_sample(3'd1, 1'b1, 32'hAAAA_AAAA);
    send_sample(3'd1, 1'b1, 32'hAAAA_AAAA + 32'd1999);
    send_sample(3'd1, 1'b1, 32'hAAAA_AAAA + 32'd2000);

    idle_on = 1'b1;
    drain();
    run_phase(100);
    stall_req = 1'b1;
    run_phase(140);
    configure(1'b1, 1, 1, 1);
    run_phase(240);
    configure(1'b1, 65535, 65535, 65535);
    run_phase(240);
    configure(1'b1, 0, 0, 0);
    run_phase(240);
    configure(1'b0, 300, 300, 2000);
    run_phase(150);
    configure(1'b1, $urandom_range(1, 1000), $urandom_range(1, 1000), $urandom_range(1, 3000));
    idle_on = 1'b0;
    run_phase(240);
    idle_on = 1'b1;
    configure(1'b1, 65535, 1, 300);
    run_phase(240);
    configure(1'b1, 50, 400, 120);
    run_phase(240);

    drain();
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
